FILE: rtl/lfu_pkg.sv
// Shared constants, result codes and controller/datapath interface types for the LFU slot unit.
package lfu_pkg;

    localparam int MAX_SLOTS = 32;                       // built slot count
    localparam int SLOT_W    = $clog2(MAX_SLOTS);        // slot index width
    localparam int NUM_W     = $clog2(MAX_SLOTS + 1);    // holds a slot count
    localparam int ID_W      = 8;
    localparam int HITS_W    = 16;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 6;
    localparam int EV_W      = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    typedef enum logic [EV_W-1:0] {
        EV_HIT        = 3'd0,
        EV_FILL       = 3'd1,
        EV_REPLACE    = 3'd2,
        EV_LIST_ENTRY = 3'd3,
        EV_LIST_EMPTY = 3'd4
    } ev_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;    // capture request, clear listing progress
        logic scan_clr;    // restart slot scan and its trackers
        logic scan_step;   // look at one slot, advance index
        logic cnt_en;      // count occupied slots on this step
        logic commit;      // apply recommend update, load result
        logic list_emit;   // load selected listing entry, move past it
        logic list_empty;  // load the listing-empty result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_dump;     // offered request is a dump
        logic in_id_zero;  // offered recommend carries id 0
        logic scan_last;   // index sits on the last active slot
        logic list_none;   // no occupied active slot
        logic list_last;   // next listing entry is the final one
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

FILE: rtl/lfu_datapath.sv
// Slot storage, scan trackers, request counter and result register of the LFU slot unit.
module lfu_datapath import lfu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic [0:0]          s_tuser,     // kind
    input  logic [7:0]          s_tdata,     // candidate_id
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,     // entry_id, evicted_id, ref_count
    output logic [EV_W-1:0]     m_tuser,     // event_res
    output logic                m_tlast
);

    logic [ID_W-1:0]    key_reg   [MAX_SLOTS];
    logic [HITS_W-1:0]  hits_reg  [MAX_SLOTS];
    logic [STAMP_W-1:0] stamp_reg [MAX_SLOTS];

    logic [CFG_W-1:0]   cfg_reg;
    logic [STAMP_W-1:0] seq_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  cap_m1;

    // recommend trackers
    logic               hit_v_reg;
    logic [SLOT_W-1:0]  hit_idx_reg;
    logic [HITS_W-1:0]  hit_hits_reg;
    logic               free_v_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic [SLOT_W-1:0]  vic_idx_reg;
    logic [HITS_W-1:0]  vic_hits_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    logic [ID_W-1:0]    vic_key_reg;

    // listing trackers
    logic [NUM_W-1:0]   list_n_reg;
    logic [NUM_W-1:0]   emit_cnt_reg;
    logic               prev_v_reg;
    logic [ID_W-1:0]    prev_key_reg;
    logic [SLOT_W-1:0]  prev_idx_reg;
    logic               sel_v_reg;
    logic [ID_W-1:0]    sel_key_reg;
    logic [SLOT_W-1:0]  sel_idx_reg;
    logic [HITS_W-1:0]  sel_hits_reg;

    // result register
    logic               m_tvalid_reg;
    ev_t                out_ev_reg;
    logic [ID_W-1:0]    out_entry_reg;
    logic [ID_W-1:0]    out_evict_reg;
    logic [HITS_W-1:0]  out_count_reg;
    logic               out_last_reg;

    logic [ID_W-1:0]    cur_key;
    logic [HITS_W-1:0]  cur_hits;
    logic [STAMP_W-1:0] cur_stamp;
    logic               vic_better;
    logic               after_prev;
    logic               sel_better;
    logic [HITS_W-1:0]  hit_inc;

    logic               wr_en;
    logic [SLOT_W-1:0]  wr_idx;
    logic [ID_W-1:0]    wr_key;
    logic [HITS_W-1:0]  wr_hits;
    logic [STAMP_W-1:0] wr_stamp;
    logic               out_load;
    ev_t                out_ev_next;
    logic [ID_W-1:0]    out_entry_next;
    logic [ID_W-1:0]    out_evict_next;
    logic [HITS_W-1:0]  out_count_next;
    logic               out_last_next;

    // active slots are 0 .. cap-1; register value 0 acts as 1, large values clamp
    always_comb begin
        if (cfg_reg == '0) begin
            cap_m1 = '0;
        end else if ({1'b0, cfg_reg} > (CFG_W+1)'(MAX_SLOTS)) begin
            cap_m1 = SLOT_W'(MAX_SLOTS - 1);
        end else begin
            cap_m1 = SLOT_W'(cfg_reg - CFG_W'(1));
        end
    end

    assign cur_key   = key_reg[idx_reg];
    assign cur_hits  = hits_reg[idx_reg];
    assign cur_stamp = stamp_reg[idx_reg];

    // strict compare keeps the lower slot on a full tie
    assign vic_better = (idx_reg == '0) || (cur_hits < vic_hits_reg) ||
                        ((cur_hits == vic_hits_reg) && (cur_stamp < vic_stamp_reg));
    // listing order is (id, slot) ascending
    assign after_prev = !prev_v_reg || (cur_key > prev_key_reg) ||
                        ((cur_key == prev_key_reg) && (idx_reg > prev_idx_reg));
    assign sel_better = (cur_key != '0) && after_prev &&
                        (!sel_v_reg || (cur_key < sel_key_reg));

    assign hit_inc = (hit_hits_reg == '1) ? hit_hits_reg : hit_hits_reg + HITS_W'(1);

    assign sts.in_dump    = s_tuser[0];
    assign sts.in_id_zero = (s_tdata == '0);
    assign sts.scan_last  = (idx_reg == cap_m1);
    assign sts.list_none  = (list_n_reg == '0);
    assign sts.list_last  = (emit_cnt_reg + NUM_W'(1) == list_n_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        wr_en          = 1'b0;
        wr_idx         = vic_idx_reg;
        wr_key         = req_id_reg;
        wr_hits        = HITS_W'(1);
        wr_stamp       = seq_reg;
        out_load       = 1'b0;
        out_ev_next    = EV_LIST_EMPTY;
        out_entry_next = '0;
        out_evict_next = '0;
        out_count_next = '0;
        out_last_next  = 1'b1;
        if (cmd.commit) begin
            wr_en          = 1'b1;
            out_load       = 1'b1;
            out_entry_next = req_id_reg;
            out_count_next = HITS_W'(1);
            priority if (hit_v_reg) begin
                wr_idx         = hit_idx_reg;
                wr_key         = req_id_reg;
                wr_hits        = hit_inc;
                wr_stamp       = stamp_reg[hit_idx_reg];
                out_ev_next    = EV_HIT;
                out_count_next = hit_inc;
            end else if (free_v_reg) begin
                wr_idx      = free_idx_reg;
                out_ev_next = EV_FILL;
            end else begin
                wr_idx         = vic_idx_reg;
                out_ev_next    = EV_REPLACE;
                out_evict_next = vic_key_reg;
            end
        end else if (cmd.list_emit) begin
            out_load       = 1'b1;
            out_ev_next    = EV_LIST_ENTRY;
            out_entry_next = sel_key_reg;
            out_count_next = sel_hits_reg;
            out_last_next  = sts.list_last;
        end else if (cmd.list_empty) begin
            out_load = 1'b1;
        end
    end

    // keys reset to empty; counts and stamps are only read after a fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SLOTS; i++) key_reg[i] <= '0;
        end else if (wr_en) begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hits_reg[wr_idx]  <= wr_hits;
            stamp_reg[wr_idx] <= wr_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_RESET;
            seq_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) cfg_reg <= cfg_wr_data;
            if (cmd.commit && seq_reg != '1) seq_reg <= seq_reg + STAMP_W'(1);
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ev_reg    <= out_ev_next;
            out_entry_reg <= out_entry_next;
            out_evict_reg <= out_evict_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
        end
    end

    // scan index and trackers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            hit_v_reg    <= 1'b0;
            free_v_reg   <= 1'b0;
            sel_v_reg    <= 1'b0;
            prev_v_reg   <= 1'b0;
            list_n_reg   <= '0;
            emit_cnt_reg <= '0;
        end else begin
            if (cmd.load_req) begin
                req_id_reg   <= s_tdata;
                prev_v_reg   <= 1'b0;
                list_n_reg   <= '0;
                emit_cnt_reg <= '0;
            end
            if (cmd.list_emit) begin
                prev_v_reg   <= 1'b1;
                prev_key_reg <= sel_key_reg;
                prev_idx_reg <= sel_idx_reg;
                emit_cnt_reg <= emit_cnt_reg + NUM_W'(1);
            end
            if (cmd.scan_clr) begin
                idx_reg    <= '0;
                hit_v_reg  <= 1'b0;
                free_v_reg <= 1'b0;
                sel_v_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (!hit_v_reg && cur_key == req_id_reg) begin
                    hit_v_reg    <= 1'b1;
                    hit_idx_reg  <= idx_reg;
                    hit_hits_reg <= cur_hits;
                end
                if (!free_v_reg && cur_key == '0) begin
                    free_v_reg   <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (vic_better) begin
                    vic_idx_reg   <= idx_reg;
                    vic_hits_reg  <= cur_hits;
                    vic_stamp_reg <= cur_stamp;
                    vic_key_reg   <= cur_key;
                end
                if (sel_better) begin
                    sel_v_reg    <= 1'b1;
                    sel_key_reg  <= cur_key;
                    sel_idx_reg  <= idx_reg;
                    sel_hits_reg <= cur_hits;
                end
                if (cmd.cnt_en && cur_key != '0) list_n_reg <= list_n_reg + NUM_W'(1);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_evict_reg, out_entry_reg};
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/lfu_ctrl.sv
// Sequencing state machine of the LFU slot unit.
module lfu_ctrl import lfu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_UPD   = 8'b0000_0100,
        ST_CNT   = 8'b0000_1000,
        ST_LPREP = 8'b0001_0000,
        ST_LSCAN = 8'b0010_0000,
        ST_LEMIT = 8'b0100_0000,
        ST_EMPTY = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    cmd.scan_clr = 1'b1;
                    priority if (sts.in_dump) begin
                        state_next = ST_CNT;
                    end else if (!sts.in_id_zero) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;   // id 0 dropped
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = ST_UPD;
            end
            ST_UPD: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CNT: begin
                cmd.scan_step = 1'b1;
                cmd.cnt_en    = 1'b1;
                if (sts.scan_last) state_next = ST_LPREP;
            end
            ST_LPREP: begin
                cmd.scan_clr = 1'b1;
                state_next   = sts.list_none ? ST_EMPTY : ST_LSCAN;
            end
            ST_LSCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = ST_LEMIT;
            end
            ST_LEMIT: begin
                if (sts.out_free) begin
                    cmd.list_emit = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    state_next    = sts.list_last ? ST_IDLE : ST_LSCAN;
                end
            end
            ST_EMPTY: begin
                if (sts.out_free) begin
                    cmd.list_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/lfu_slot_replacement_unit.sv
// Top level of the LFU slot replacement unit: controller plus datapath.
// Holds up to 32 slots of (id, reference count, insertion stamp). A recommend
// request (s_tuser = 0) with a nonzero id hits, fills the lowest free active slot
// or evicts the active slot with the lowest count, oldest insertion on a tie,
// lowest slot on a full tie; it returns one result. A recommend for id 0 is
// dropped without a result. A dump request (s_tuser = 1) lists the occupied
// active slots by ascending id (equal ids in slot order), last one flagged with
// m_tlast, or returns a single listing-empty result. Active slots are 0 ..
// cap-1, cap being cfg_wr_data as last written, clamped to 1..32 (reset 32);
// write it only while no request is in progress. The slot store is scanned
// one slot per cycle. A recommend scans the active slots, then commits its
// result once the result register is free; a dropped id-0 recommend ends at
// acceptance. A dump scans once to count entries, then runs a fresh minimum
// search over the slots for each listed entry, or gives the listing-empty
// result. The result register can also hold a result while m_tready is low. A new
// request is taken as soon as the unit is back to idle, even while the final
// result is still waiting to be taken.
module lfu_slot_replacement_unit import lfu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: slots_in_use
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] candidate_id
    input  logic [0:0]         s_tuser,   // [0] kind: 0 recommend, 1 dump
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [7:0] entry_id, [15:8] evicted_id,
                                          // [31:16] ref_count
    output logic [EV_W-1:0]    m_tuser,   // [2:0] event_res
    output logic               m_tlast    // final result of the request
);

    cmd_t cmd;
    sts_t sts;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfu_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the LFU slot replacement unit.
module testbench;
    import lfu_pkg::*;

    localparam logic KIND_RECOMMEND = 1'b0;
    localparam logic KIND_DUMP      = 1'b1;
    localparam int   RUN_LIMIT      = 20 * 6_000_000;  // time units
    localparam int   DRAIN_CYCLES   = 50;              // settle margin before a register write
    localparam int   HIT_RUN        = 6;               // repeated hits on one id

    // One expected result of the unit.
    typedef struct {
        ev_t                ev;
        logic [ID_W-1:0]    entry;
        logic [ID_W-1:0]    evicted;
        logic [HITS_W-1:0]  count;
        logic               last;
    } lfu_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;      // [7:0] candidate_id
    logic [0:0]         s_tuser = '0;      // [0] kind
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [31:0]        m_tdata;           // [7:0] entry_id, [15:8] evicted_id,
                                           // [31:16] ref_count
    logic [EV_W-1:0]    m_tuser;           // [2:0] event_res
    logic               m_tlast;

    // Shadow copy of the slot store, used to predict every result.
    logic [ID_W-1:0]    pred_key   [MAX_SLOTS];
    logic [HITS_W-1:0]  pred_count [MAX_SLOTS];
    logic [STAMP_W-1:0] pred_stamp [MAX_SLOTS];
    logic [STAMP_W-1:0] pred_seq = '0;
    logic [CFG_W-1:0]   pred_cap = CFG_RESET;

    lfu_result_t        pending_results[$];
    int                 error_count = 0;
    bit                 idle_on = 1'b1;    // random gaps on both channels

    lfu_slot_replacement_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            pred_key[i]   = '0;
            pred_count[i] = '0;
            pred_stamp[i] = '0;
        end
    end

    // Register value -> number of searched slots (0 acts as 1, clamp at built size).
    function automatic int active_count(input logic [CFG_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(value);
    endfunction

    function automatic void push_result(input ev_t ev, input logic [ID_W-1:0] entry,
                                        input logic [ID_W-1:0] evicted,
                                        input logic [HITS_W-1:0] count, input logic last);
        lfu_result_t r;
        r.ev      = ev;
        r.entry   = entry;
        r.evicted = evicted;
        r.count   = count;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow store and queue its results.
    function automatic void lfu_predict(input logic kind, input logic [ID_W-1:0] id);
        int               act;
        int               hit;
        int               free_slot;
        int               victim;
        int               n;
        int               j;
        int               s;
        int               order[MAX_SLOTS];
        logic [STAMP_W-1:0] stamp;
        act = active_count(pred_cap);
        if (kind == KIND_RECOMMEND) begin
            if (id == 0)
                return;                          // dropped, no result, no state change
            stamp = pred_seq;
            if (pred_seq != '1)
                pred_seq++;
            hit       = -1;
            free_slot = -1;
            victim    = 0;
            for (int i = 0; i < act; i++) begin
                if (hit < 0 && pred_key[i] == id)
                    hit = i;                     // duplicates: lowest slot wins
                if (free_slot < 0 && pred_key[i] == 0)
                    free_slot = i;
            end
            if (hit >= 0) begin
                if (pred_count[hit] != '1)
                    pred_count[hit]++;
                push_result(EV_HIT, id, '0, pred_count[hit], 1'b1);
            end else if (free_slot >= 0) begin
                pred_key[free_slot]   = id;
                pred_count[free_slot] = HITS_W'(1);
                pred_stamp[free_slot] = stamp;
                push_result(EV_FILL, id, '0, 16'd1, 1'b1);
            end else begin
                // lowest count, then oldest stamp, then lowest slot
                for (int i = 1; i < act; i++) begin
                    if (pred_count[i] < pred_count[victim] ||
                        (pred_count[i] == pred_count[victim] &&
                         pred_stamp[i] < pred_stamp[victim]))
                        victim = i;
                end
                push_result(EV_REPLACE, id, pred_key[victim], 16'd1, 1'b1);
                pred_key[victim]   = id;
                pred_count[victim] = HITS_W'(1);
                pred_stamp[victim] = stamp;
            end
        end else begin
            n = 0;
            for (int i = 0; i < act; i++) begin
                if (pred_key[i] != 0) begin
                    order[n] = i;
                    n++;
                end
            end
            if (n == 0) begin
                push_result(EV_LIST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
                // stable sort: equal ids keep slot order
                for (int i = 1; i < n; i++) begin
                    s = order[i];
                    j = i;
                    while (j > 0 && pred_key[order[j-1]] > pred_key[s]) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = s;
                end
                // n never exceeds MAX_SLOTS, the built slot count
                for (int k = 0; k < n; k++)
                    push_result(EV_LIST_ENTRY, pred_key[order[k]], '0,
                                pred_count[order[k]], k == n - 1);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    // Result side: random backpressure, changed on the falling edge.
    always @(negedge aclk)
        m_tready <= !idle_on || ($urandom_range(99) >= 15);

    // Compare each taken result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        lfu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d id=%0d",
                                          m_tuser, m_tdata[7:0]));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.ev)
                    report_mismatch($sformatf("event_res %0d, want %0d", m_tuser, want.ev));
                if (m_tdata[7:0] !== want.entry)
                    report_mismatch($sformatf("entry_id %0d, want %0d",
                                              m_tdata[7:0], want.entry));
                if (m_tdata[15:8] !== want.evicted)
                    report_mismatch($sformatf("evicted_id %0d, want %0d",
                                              m_tdata[15:8], want.evicted));
                if (m_tdata[31:16] !== want.count)
                    report_mismatch($sformatf("ref_count %0d, want %0d",
                                              m_tdata[31:16], want.count));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    // Drive one request; valid stays up after acceptance until the next falling edge.
    task automatic send_request(input logic kind, input logic [ID_W-1:0] id);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        lfu_predict(kind, id);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Register write: only once the unit has gone quiet.
    task automatic write_cap(input logic [CFG_W-1:0] value);
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge aclk);
        // extra settle margin after the last result
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        pred_cap = value;
    endtask

    // Empty listing, fills, dropped id 0, ascending listing, hit.
    task automatic test_fill_and_listing();
        send_request(KIND_DUMP, 8'hFF);
        send_request(KIND_RECOMMEND, 8'd1);
        send_request(KIND_RECOMMEND, 8'd255);
        send_request(KIND_RECOMMEND, 8'd128);
        send_request(KIND_RECOMMEND, 8'd0);
        send_request(KIND_DUMP, 8'h00);
        send_request(KIND_RECOMMEND, 8'd255);
        send_request(KIND_DUMP, 8'h55);
    endtask

    // Two active slots: lowest count goes, then oldest insertion on a count tie.
    task automatic test_victim_choice();
        write_cap(6'd2);
        send_request(KIND_RECOMMEND, 8'd7);
        send_request(KIND_RECOMMEND, 8'd9);
        send_request(KIND_RECOMMEND, 8'd9);
        send_request(KIND_RECOMMEND, 8'd11);
        send_request(KIND_DUMP, 8'h00);
    endtask

    // Register 0 and 63, inactive slots kept, duplicate ids after a cap change.
    task automatic test_cap_limits();
        write_cap(6'd0);
        send_request(KIND_RECOMMEND, 8'd40);
        send_request(KIND_DUMP, 8'h00);
        write_cap(6'd1);
        send_request(KIND_RECOMMEND, pred_key[1]);   // copy slot 1's id into slot 0
        write_cap(6'd63);
        send_request(KIND_DUMP, 8'h00);
        send_request(KIND_RECOMMEND, pred_key[1]);   // hit goes to the lower copy
        send_request(KIND_DUMP, 8'h00);
    endtask

    // One slot, one id hit back to back; no gaps here.
    task automatic test_repeat_hits();
        write_cap(6'd1);
        idle_on = 1'b0;
        for (int i = 0; i <= HIT_RUN; i++)
            send_request(KIND_RECOMMEND, 8'd77);
        send_request(KIND_DUMP, 8'h00);
        send_request(KIND_RECOMMEND, 8'd78);
        idle_on = 1'b1;
    endtask

    // Phases over several cap settings; mostly small ids to force hits and evictions.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] caps[12] = '{6'd1, 6'd2, 6'd4, 6'd32, 6'd0, 6'd63,
                                       6'd8, 6'd33, 6'd16, 6'd0, 6'd3, 6'd32};
        logic [CFG_W-1:0] value;
        int               act;
        int               pick;
        for (int p = 0; p < 12; p++) begin
            value = (p == 9) ? CFG_W'($urandom_range(1, 32)) : caps[p];
            write_cap(value);
            act = active_count(value);
            idle_on = (p != 6);                  // one phase runs without gaps
            for (int k = 0; k < 35; k++) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    send_request(KIND_DUMP, ID_W'($urandom_range(255)));
                else if (pick < 12)
                    send_request(KIND_RECOMMEND, 8'd0);
                else if (pick < 60)
                    send_request(KIND_RECOMMEND, ID_W'($urandom_range(1, act + act / 2 + 2)));
                else
                    send_request(KIND_RECOMMEND, ID_W'($urandom_range(1, 255)));
            end
            send_request(KIND_DUMP, ID_W'($urandom_range(255)));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_fill_and_listing();
        test_victim_choice();
        test_cap_limits();
        test_repeat_hits();
        test_random_traffic();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
